[hdl/sifs_pkg.sv]
// Package with the types, character codes and digit decoder of the integer field scanner.
`timescale 1ns / 1ps
`default_nettype none
package sifs_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 255;
   localparam int VALUE_BITS_DEFAULT = 64;
   localparam int RESULT_BITS        = 64;

   // Character codes the scanner reacts to.
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A_UP  = 8'h41;
   localparam logic [7:0] CH_F_UP  = 8'h46;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_A_LO  = 8'h61;
   localparam logic [7:0] CH_F_LO  = 8'h66;
   localparam logic [7:0] CH_X_LO  = 8'h78;

   localparam logic [4:0] NO_DIGIT = 5'd16;

   typedef enum logic [1:0] {
      RX_DEC  = 2'd0,
      RX_AUTO = 2'd1,
      RX_OCT  = 2'd2,
      RX_HEX  = 2'd3
   } radix_type;

   typedef enum logic [4:0] {
      PH_SPACE = 5'b00001,
      PH_LEAD  = 5'b00010,
      PH_ZERO  = 5'b00100,
      PH_DIG   = 5'b01000,
      PH_DONE  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] width;
      logic [1:0] opcode;
      logic       start;
      logic [7:0] ch;
   } item_type;

   typedef struct packed {
      logic                   consumed;
      logic                   done;
      logic [RESULT_BITS-1:0] value;
   } result_type;

   // Digit value of a character in the given radix, NO_DIGIT if it is none.
   function automatic logic [4:0] digit_of(input logic [7:0] c, input radix_type rx);
      logic [4:0] d;
      d = NO_DIGIT;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = 5'(c - CH_ZERO);
      end else if (c >= CH_A_LO && c <= CH_F_LO) begin
         d = 5'(c - CH_A_LO) + 5'd10;
      end else if (c >= CH_A_UP && c <= CH_F_UP) begin
         d = 5'(c - CH_A_UP) + 5'd10;
      end
      case (rx)
         RX_HEX:  digit_of = d;
         RX_OCT:  digit_of = (d < 5'd8) ? d : NO_DIGIT;
         default: digit_of = (d < 5'd10) ? d : NO_DIGIT;
      endcase
   endfunction

endpackage
`default_nettype wire

[hdl/scanf_integer_field_scanner.sv]
// Top level of the integer field scanner: input register, scanner step and result register.
//
//  Channel | Direction | tdata                      | tuser                    | tlast
//  req     | in        | [7:0] ch, [15:8] width     | [0] start_req, [2:1] op  | -
//  rsp     | out       | [63:0] value               | [0] consumed             | done_res
//
// One character is taken per cycle while rsp is not stalled; a transfer on req passes
// through the input register and then the result register, around the single step of the
// scanner state, before its result appears on rsp.
// Reset clears the handshake valids and puts the scanner in space skipping, decimal,
// unlimited width.
// A stall on rsp holds the result register; req keeps accepting until the input register
// is also full.
`timescale 1ns / 1ps
`default_nettype none
module scanf_integer_field_scanner #(
   parameter int MAX_WIDTH  = sifs_pkg::MAX_WIDTH_DEFAULT,
   parameter int VALUE_BITS = sifs_pkg::VALUE_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [7:0] ch, [15:8] width
   input  wire  [2:0]  req_tuser,   // [0] start_req, [2:1] opcode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] value
   output logic        rsp_tuser,   // [0] consumed
   output logic        rsp_tlast
);

   logic                 in_valid_ff, in_valid_in;
   sifs_pkg::item_type   in_item_ff;
   logic                 out_valid_ff, out_valid_in;
   sifs_pkg::result_type out_res_ff;
   sifs_pkg::result_type step_res;
   logic                 req_fire;
   logic                 advance;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   sifs_core #(
      .MAX_WIDTH  (MAX_WIDTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .res     (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.ch     <= req_tdata[7:0];
         in_item_ff.width  <= req_tdata[15:8];
         in_item_ff.start  <= req_tuser[0];
         in_item_ff.opcode <= req_tuser[2:1];
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_res_ff.value;
   assign rsp_tuser  = out_res_ff.consumed;
   assign rsp_tlast  = out_res_ff.done;

endmodule
`default_nettype wire

[hdl/sifs_core.sv]
// Scanner state and the per-character step: sign, prefix, digit accumulate and width count.
`timescale 1ns / 1ps
`default_nettype none
module sifs_core #(
   parameter int MAX_WIDTH  = sifs_pkg::MAX_WIDTH_DEFAULT,
   parameter int VALUE_BITS = sifs_pkg::VALUE_BITS_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  step_en,
   input  wire sifs_pkg::item_type item,
   output sifs_pkg::result_type res
);

   localparam int CntW  = $clog2(MAX_WIDTH + 1);
   localparam int WideW = (CntW > 8) ? CntW : 8;

   sifs_pkg::phase_type     phase_ff, phase_in;
   sifs_pkg::radix_type     radix_ff, radix_in;
   logic                    negative_ff, negative_in;
   logic                    unlimited_ff, unlimited_in;
   logic [CntW-1:0]         chars_left_ff, chars_left_in;
   logic [VALUE_BITS-1:0]   value_ff, value_in;

   // Effective state after an optional start of a new field.
   sifs_pkg::phase_type     ph;
   sifs_pkg::radix_type     rdx;
   logic                    neg;
   logic                    unl;
   logic [CntW-1:0]         chars;
   logic [VALUE_BITS-1:0]   val;

   logic [WideW-1:0]        w_wide;
   logic [WideW-1:0]        w_clamp;
   sifs_pkg::radix_type     rx_use;
   logic [4:0]              digit;
   logic                    digit_ok;
   logic [VALUE_BITS-1:0]   scaled;
   logic [VALUE_BITS-1:0]   acc;
   logic                    is_ws;
   logic                    is_x;
   logic                    is_sign;
   logic                    take_ok;
   sifs_pkg::phase_type     ph_t;
   sifs_pkg::radix_type     rdx_t;
   logic                    neg_t;
   logic [VALUE_BITS-1:0]   val_t;
   logic [CntW-1:0]         chars_dec;

   assign w_wide  = WideW'(item.width);
   assign w_clamp = (w_wide > WideW'(MAX_WIDTH)) ? WideW'(MAX_WIDTH) : w_wide;

   always_comb begin
      if (item.start) begin
         ph    = sifs_pkg::PH_SPACE;
         rdx   = sifs_pkg::radix_type'(item.opcode);
         neg   = 1'b0;
         unl   = (item.width == 8'd0);
         chars = CntW'(w_clamp);
         val   = '0;
      end else begin
         ph    = phase_ff;
         rdx   = radix_ff;
         neg   = negative_ff;
         unl   = unlimited_ff;
         chars = chars_left_ff;
         val   = value_ff;
      end
   end

   assign is_ws   = (item.ch == sifs_pkg::CH_SPACE) ||
                    (item.ch >= sifs_pkg::CH_TAB && item.ch <= sifs_pkg::CH_CR);
   assign is_x    = (item.ch == sifs_pkg::CH_X_LO) || (item.ch == sifs_pkg::CH_X_UP);
   assign is_sign = (item.ch == sifs_pkg::CH_PLUS) || (item.ch == sifs_pkg::CH_MINUS);

   // Auto-base resolves to decimal on a leading nonzero digit and to octal after a zero.
   always_comb begin
      if (ph == sifs_pkg::PH_ZERO || ph == sifs_pkg::PH_DIG) begin
         rx_use = (rdx == sifs_pkg::RX_AUTO) ? sifs_pkg::RX_OCT : rdx;
      end else begin
         rx_use = (rdx == sifs_pkg::RX_AUTO) ? sifs_pkg::RX_DEC : rdx;
      end
   end

   assign digit    = sifs_pkg::digit_of(item.ch, rx_use);
   assign digit_ok = (digit != sifs_pkg::NO_DIGIT);

   // The value is kept already signed, so a minus sign subtracts each digit.
   always_comb begin
      case (rx_use)
         sifs_pkg::RX_HEX: scaled = val << 4;
         sifs_pkg::RX_OCT: scaled = val << 3;
         default:          scaled = (val << 3) + (val << 1);
      endcase
      acc = neg ? (scaled - VALUE_BITS'(digit)) : (scaled + VALUE_BITS'(digit));
   end

   always_comb begin
      take_ok = 1'b0;
      ph_t    = ph;
      rdx_t   = rdx;
      neg_t   = neg;
      val_t   = val;
      unique case (ph) inside
         sifs_pkg::PH_SPACE, sifs_pkg::PH_LEAD: begin
            if (ph == sifs_pkg::PH_SPACE && rdx != sifs_pkg::RX_HEX && is_sign) begin
               neg_t   = (item.ch == sifs_pkg::CH_MINUS);
               ph_t    = sifs_pkg::PH_LEAD;
               take_ok = 1'b1;
            end else if ((rdx == sifs_pkg::RX_AUTO || rdx == sifs_pkg::RX_HEX) &&
                         item.ch == sifs_pkg::CH_ZERO) begin
               ph_t    = sifs_pkg::PH_ZERO;
               take_ok = 1'b1;
            end else if (digit_ok) begin
               val_t   = acc;
               rdx_t   = rx_use;
               ph_t    = sifs_pkg::PH_DIG;
               take_ok = 1'b1;
            end
         end
         sifs_pkg::PH_ZERO: begin
            if (is_x) begin
               rdx_t   = sifs_pkg::RX_HEX;
               ph_t    = sifs_pkg::PH_DIG;
               take_ok = 1'b1;
            end else if (digit_ok) begin
               rdx_t   = rx_use;
               val_t   = acc;
               ph_t    = sifs_pkg::PH_DIG;
               take_ok = 1'b1;
            end
         end
         sifs_pkg::PH_DIG: begin
            if (digit_ok) begin
               rdx_t   = rx_use;
               val_t   = acc;
               take_ok = 1'b1;
            end
         end
         default: begin
            take_ok = 1'b0;
         end
      endcase
   end

   assign chars_dec = chars - CntW'(1);

   always_comb begin
      phase_in      = ph;
      radix_in      = rdx;
      negative_in   = neg;
      unlimited_in  = unl;
      chars_left_in = chars;
      value_in      = val;
      res.consumed  = 1'b0;
      res.done      = 1'b0;
      if (ph == sifs_pkg::PH_DONE) begin
         res.done = 1'b1;
      end else if (ph == sifs_pkg::PH_SPACE && is_ws) begin
         res.consumed = 1'b1;
      end else if (!unl && chars == '0) begin
         phase_in = sifs_pkg::PH_DONE;
         res.done = 1'b1;
      end else if (take_ok) begin
         res.consumed = 1'b1;
         phase_in     = ph_t;
         radix_in     = rdx_t;
         negative_in  = neg_t;
         value_in     = val_t;
         if (!unl) begin
            chars_left_in = chars_dec;
            if (chars_dec == '0) begin
               phase_in = sifs_pkg::PH_DONE;
               res.done = 1'b1;
            end
         end
      end else begin
         phase_in = sifs_pkg::PH_DONE;
         res.done = 1'b1;
      end
      res.value = sifs_pkg::RESULT_BITS'(signed'(value_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= sifs_pkg::PH_SPACE;
         radix_ff      <= sifs_pkg::RX_DEC;
         negative_ff   <= 1'b0;
         unlimited_ff  <= 1'b1;
         chars_left_ff <= '0;
         value_ff      <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         radix_ff      <= radix_in;
         negative_ff   <= negative_in;
         unlimited_ff  <= unlimited_in;
         chars_left_ff <= chars_left_in;
         value_ff      <= value_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      step_en && !item.start && phase_ff == sifs_pkg::PH_DONE |-> res.done && !res.consumed)
      else $error("ended field took a character");

   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      step_en && res.done |=> phase_ff == sifs_pkg::PH_DONE)
      else $error("field end not recorded in phase");

   a_value_hold: assert property (@(posedge clock) disable iff (reset)
      step_en && !item.start && !res.consumed |=> $stable(value_ff))
      else $error("value changed on a character that was not taken");

   a_width_used: assert property (@(posedge clock) disable iff (reset)
      !unlimited_ff && chars_left_ff == '0 |-> phase_ff == sifs_pkg::PH_DONE)
      else $error("width used up but field still open");
`endif

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the integer field scanner: directed script, then random fields.
`timescale 1ns / 1ps
module tb_top;
   import sifs_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int ITEM_GOAL   = 825;
   localparam int NOT_DIGIT   = 16;

   typedef struct {
      logic [7:0]  ch;
      logic        start;
      radix_type   op;
      logic [7:0]  width;
      logic        known;
      logic        took;
      logic        ended;
      logic [63:0] val;
   } step_row;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   // Scanner state as seen by the predictor.
   phase_type   ph;
   logic [63:0] mag;
   logic        minus;
   radix_type   base_sel;
   logic [7:0]  budget;
   logic        no_limit;

   result_type  pending_results[$];
   result_type  oldest;
   step_row     script[25];
   int          errors;
   int          sent;
   int          quiet_cycles;
   logic        steady;

   scanf_integer_field_scanner uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic int digit_val(input logic [7:0] c, input radix_type rx);
      int d;
      if (c >= CH_ZERO && c <= CH_NINE) d = int'(c - CH_ZERO);
      else if (c >= CH_A_LO && c <= CH_F_LO) d = int'(c - CH_A_LO) + 10;
      else if (c >= CH_A_UP && c <= CH_F_UP) d = int'(c - CH_A_UP) + 10;
      else d = NOT_DIGIT;
      if (rx == RX_OCT && d > 7) d = NOT_DIGIT;
      else if (rx != RX_HEX && d > 9) d = NOT_DIGIT;
      return d;
   endfunction

   function automatic logic add_digit(input logic [7:0] c);
      int d;
      d = digit_val(c, base_sel);
      if (d == NOT_DIGIT) return 1'b0;
      case (base_sel)
         RX_HEX:  mag = mag * 64'd16 + 64'(d);
         RX_OCT:  mag = mag * 64'd8 + 64'(d);
         default: mag = mag * 64'd10 + 64'(d);
      endcase
      ph = PH_DIG;
      return 1'b1;
   endfunction

   // Advances the predicted scanner by one character and returns its result.
   function automatic result_type scan_char(input item_type it);
      result_type r;
      logic took;
      r = '0;
      took = 1'b0;
      if (it.start) begin
         ph = PH_SPACE;
         mag = '0;
         minus = 1'b0;
         base_sel = radix_type'(it.opcode);
         budget = it.width;
         no_limit = (it.width == 8'd0);
      end
      if (ph == PH_DONE) begin
         r.done = 1'b1;
      end else if (ph == PH_SPACE &&
                   (it.ch == CH_SPACE || (it.ch >= CH_TAB && it.ch <= CH_CR))) begin
         r.consumed = 1'b1;
      end else if (!no_limit && budget == 8'd0) begin
         ph = PH_DONE;
         r.done = 1'b1;
      end else begin
         if (ph == PH_SPACE && base_sel != RX_HEX &&
             (it.ch == CH_PLUS || it.ch == CH_MINUS)) begin
            minus = (it.ch == CH_MINUS);
            ph = PH_LEAD;
            took = 1'b1;
         end else if (ph == PH_SPACE || ph == PH_LEAD) begin
            if ((base_sel == RX_AUTO || base_sel == RX_HEX) && it.ch == CH_ZERO) begin
               ph = PH_ZERO;
               took = 1'b1;
            end else begin
               // In auto-base mode a nonzero leading digit commits to decimal.
               if (base_sel == RX_AUTO && it.ch >= CH_ONE && it.ch <= CH_NINE) begin
                  base_sel = RX_DEC;
               end
               took = add_digit(it.ch);
            end
         end else if (ph == PH_ZERO && (it.ch == CH_X_LO || it.ch == CH_X_UP)) begin
            base_sel = RX_HEX;
            ph = PH_DIG;
            took = 1'b1;
         end else begin
            if (base_sel == RX_AUTO) base_sel = RX_OCT;
            took = add_digit(it.ch);
         end
         if (took) begin
            r.consumed = 1'b1;
            if (!no_limit) begin
               budget--;
               if (budget == 8'd0) begin
                  ph = PH_DONE;
                  r.done = 1'b1;
               end
            end
         end else begin
            ph = PH_DONE;
            r.done = 1'b1;
         end
      end
      r.value = minus ? -mag : mag;
      return r;
   endfunction

   // Offers one character, waits for its transfer and files the expected result.
   task automatic send_char(input item_type it, input logic known, input result_type typed);
      result_type guess;
      while (!steady && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.width, it.ch};
      req_tuser  <= {it.opcode, it.start};
      do @(posedge clock); while (!req_tready);
      guess = scan_char(it);
      pending_results.push_back(known ? typed : guess);
      sent++;
   endtask

   // Builds a field: blanks, sign, prefix, digits, end and trailing bytes, or random bytes.
   task automatic send_field();
      logic [7:0] text[$];
      radix_type  op;
      radix_type  digs;
      logic [7:0] w;
      int         n;
      int         v;
      item_type   it;
      result_type none;
      none = '0;
      steady <= (sent >= 300 && sent < 450);
      op = radix_type'(2'($urandom_range(3)));
      v = $urandom_range(9);
      if (v < 5) w = 8'd0;
      else if (v < 9) w = 8'($urandom_range(24, 1));
      else w = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(5, 1);
         repeat (n) text.push_back(8'($urandom_range(255)));
      end else begin
         n = $urandom_range(2);
         repeat (n) text.push_back($urandom_range(1) ? CH_SPACE : CH_TAB + 8'($urandom_range(4)));
         if ((op != RX_HEX || $urandom_range(4) == 0) && $urandom_range(2) == 0) begin
            text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
         end
         digs = (op == RX_AUTO) ? RX_DEC : op;
         if ((op == RX_HEX && $urandom_range(1)) || (op == RX_AUTO && $urandom_range(2) == 0)) begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(1) ? CH_X_LO : CH_X_UP);
            digs = RX_HEX;
         end else if (op == RX_AUTO && $urandom_range(1)) begin
            text.push_back(CH_ZERO);
            digs = RX_OCT;
         end
         if ($urandom_range(9) == 0) digs = RX_HEX;
         n = ($urandom_range(3) == 0) ? $urandom_range(24, 14) : $urandom_range(8, 1);
         repeat (n) begin
            v = $urandom_range(digs == RX_HEX ? 15 : (digs == RX_OCT ? 7 : 9));
            if (v < 10) text.push_back(CH_ZERO + 8'(v));
            else text.push_back(8'(v - 10) + ($urandom_range(1) ? CH_A_LO : CH_A_UP));
         end
         // With no ending character the next start cuts the field short.
         v = $urandom_range(3);
         if (v == 1) text.push_back(8'h00);
         else if (v > 1) text.push_back(8'($urandom_range(255)));
         n = $urandom_range(2);
         repeat (n) text.push_back(8'($urandom_range(255)));
      end
      foreach (text[i]) begin
         it.ch     = text[i];
         it.start  = (i == 0);
         it.opcode = (i == 0) ? op : 2'($urandom_range(3));
         it.width  = (i == 0) ? w : 8'($urandom_range(255));
         send_char(it, 1'b0, none);
      end
   endtask

   initial begin
      item_type   it;
      result_type typed;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      steady     = 1'b0;
      errors     = 0;
      sent       = 0;
      ph         = PH_SPACE;
      mag        = '0;
      minus      = 1'b0;
      base_sel   = RX_DEC;
      budget     = 8'd0;
      no_limit   = 1'b1;
      script = '{
         // Without a start the scanner reads a decimal field of unlimited width.
         '{"7",      1'b0, RX_DEC,  8'd0,   1'b1, 1'b1, 1'b0, 64'd7},
         '{8'h00,    1'b0, RX_DEC,  8'd0,   1'b1, 1'b0, 1'b1, 64'd7},
         '{"5",      1'b0, RX_DEC,  8'd0,   1'b1, 1'b0, 1'b1, 64'd7},
         '{CH_SPACE, 1'b1, RX_DEC,  8'd0,   1'b1, 1'b1, 1'b0, 64'd0},
         '{CH_TAB,   1'b0, RX_DEC,  8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{CH_MINUS, 1'b0, RX_DEC,  8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"1",      1'b0, RX_DEC,  8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"2",      1'b0, RX_DEC,  8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"a",      1'b0, RX_DEC,  8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"0",      1'b1, RX_AUTO, 8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"x",      1'b0, RX_AUTO, 8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"1",      1'b0, RX_AUTO, 8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"F",      1'b0, RX_AUTO, 8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"g",      1'b0, RX_AUTO, 8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"0",      1'b1, RX_AUTO, 8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"1",      1'b0, RX_AUTO, 8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"7",      1'b0, RX_AUTO, 8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"8",      1'b0, RX_AUTO, 8'd0,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"0",      1'b1, RX_HEX,  8'd3,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"X",      1'b0, RX_HEX,  8'd3,   1'b0, 1'b0, 1'b0, 64'd0},
         '{"f",      1'b0, RX_HEX,  8'd3,   1'b0, 1'b0, 1'b0, 64'd0},
         // Hex mode takes no sign, so a plus ends the field untouched.
         '{CH_PLUS,  1'b1, RX_HEX,  8'd0,   1'b1, 1'b0, 1'b1, 64'd0},
         '{CH_MINUS, 1'b1, RX_DEC,  8'd1,   1'b1, 1'b1, 1'b1, 64'd0},
         '{"8",      1'b1, RX_OCT,  8'd0,   1'b1, 1'b0, 1'b1, 64'd0},
         '{8'hFF,    1'b1, RX_HEX,  8'hFF,  1'b1, 1'b0, 1'b1, 64'd0}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (script[i]) begin
         it.ch        = script[i].ch;
         it.start     = script[i].start;
         it.opcode    = script[i].op;
         it.width     = script[i].width;
         typed.consumed = script[i].took;
         typed.done     = script[i].ended;
         typed.value    = script[i].val;
         send_char(it, script[i].known, typed);
      end
      while (sent < ITEM_GOAL) send_field();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= steady || ($urandom_range(99) >= 35);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            flag_mismatch("result transfer with no result expected");
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_tuser !== oldest.consumed) begin
               flag_mismatch($sformatf("consumed %b, expected %b", rsp_tuser, oldest.consumed));
            end
            if (rsp_tlast !== oldest.done) begin
               flag_mismatch($sformatf("done %b, expected %b", rsp_tlast, oldest.done));
            end
            if (rsp_tdata !== oldest.value) begin
               flag_mismatch($sformatf("value %h, expected %h", rsp_tdata, oldest.value));
            end
         end
      end
   end

   // Ends the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

[filelist.f]
hdl/sifs_pkg.sv
hdl/sifs_core.sv
hdl/scanf_integer_field_scanner.sv
bench/tb_top.sv
